// ===== sv/psl_pkg.sv =====
package psl_pkg;

  // List geometry.
  localparam int DEPTH      = 128;
  localparam int DATA_WIDTH = 32;

  // The count must also hold DEPTH itself.
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Positions and cell indexes are compared at this width.
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

  // The read OR tree is split into groups of this many cells.
  localparam int RD_GRP = 16;
  localparam int GRP_N  = (DEPTH + RD_GRP - 1) / RD_GRP;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_INSERT = 2'd2,
    OP_DELETE = 2'd3
  } psl_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } psl_status_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  position;
    logic [31:0] value;
  } psl_in_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  status;
    logic [7:0]  length;
    logic        empty_res;
  } psl_out_t;

  // Command broadcast from the control to every cell.
  typedef struct packed {
    logic                  wr_en;
    logic                  ins_en;
    logic                  del_en;
    logic                  rd_en;
    logic [CMP_W-1:0]      tgt;
    logic [DATA_WIDTH-1:0] data;
  } psl_ctrl_t;

  // Fit a 32-bit request value to the stored width.
  function automatic logic [DATA_WIDTH-1:0] to_data(input logic [31:0] v);
    logic [63:0] t;
    t = {32'b0, v};
    return t[DATA_WIDTH-1:0];
  endfunction

  // Fit a stored word to the 32-bit result field.
  function automatic logic [31:0] from_data(input logic [DATA_WIDTH-1:0] d);
    logic [63:0] t;
    t = '0;
    t[DATA_WIDTH-1:0] = d;
    return t[31:0];
  endfunction

  // Fit the count to the 8-bit length field.
  function automatic logic [7:0] to_len(input logic [CNT_W-1:0] c);
    logic [15:0] t;
    t = '0;
    t[CNT_W-1:0] = c;
    return t[7:0];
  endfunction

endpackage

// ===== sv/psl_cell.sv =====
module psl_cell import psl_pkg::*; (
  input  logic                  clk,
  input  psl_ctrl_t             ctrl,
  input  logic [CMP_W-1:0]      cell_idx,
  input  logic [DATA_WIDTH-1:0] prev_entry,
  input  logic [DATA_WIDTH-1:0] next_entry,
  output logic [DATA_WIDTH-1:0] entry,
  output logic [DATA_WIDTH-1:0] rd_tap
);

  logic [DATA_WIDTH-1:0] entry_r;
  logic [DATA_WIDTH-1:0] entry_nxt;
  logic                  at_tgt;
  logic                  above_tgt;

  // Where this cell sits relative to the target position.
  assign at_tgt    = (cell_idx == ctrl.tgt);
  assign above_tgt = (cell_idx > ctrl.tgt);

  // Overwrite at the target, take the lower neighbor on insert, the upper on delete.
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.wr_en && at_tgt) begin
      entry_nxt = ctrl.data;
    end else if (ctrl.ins_en) begin
      if (above_tgt) begin
        entry_nxt = prev_entry;
      end else if (at_tgt) begin
        entry_nxt = ctrl.data;
      end
    end else if (ctrl.del_en && (at_tgt || above_tgt)) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry  = entry_r;
  assign rd_tap = (ctrl.rd_en && at_tgt) ? entry_r : '0;

endmodule

// ===== sv/psl_rdtree.sv =====
module psl_rdtree import psl_pkg::*; (
  input  logic                  clk,
  input  logic [DATA_WIDTH-1:0] taps [DEPTH],
  output logic [DATA_WIDTH-1:0] rd_data
);

  logic [DATA_WIDTH-1:0] grp_r   [GRP_N];
  logic [DATA_WIDTH-1:0] grp_nxt [GRP_N];

  // First level: OR each group of cells, then register.
  always_comb begin
    for (int g = 0; g < GRP_N; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < RD_GRP; k++) begin
        if (g * RD_GRP + k < DEPTH) begin
          grp_nxt[g] = grp_nxt[g] | taps[g * RD_GRP + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < GRP_N; g++) begin
      grp_r[g] <= grp_nxt[g];
    end
  end

  // Second level: OR the registered groups.
  always_comb begin
    rd_data = '0;
    for (int g = 0; g < GRP_N; g++) begin
      rd_data = rd_data | grp_r[g];
    end
  end

endmodule

// ===== sv/positional_shift_list.sv =====
// Channel  | Ports                          | Handshake
// ---------+--------------------------------+-------------------------------------
// request  | start, busy, in_req            | taken when start is high, busy low
// result   | out_valid, out_rsp             | one-cycle strobe, cannot be stalled
//
// A request is taken at a clock edge; its result follows the ph1_r and ph2_r phases.
// busy is high in the cycle after each request, so no new request is taken while
// the list cells update; the read data then crosses a registered two-level OR tree
// into the output register.
// Reset (synchronous, active low) empties the list; cell contents are not cleared.
// The receiver cannot stall, so results never back up.
module positional_shift_list import psl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  psl_in_t  in_req,
  output logic     out_valid,
  output psl_out_t out_rsp
);

  logic                  ph1_r;
  logic                  ph2_r;
  logic                  out_valid_r;
  psl_in_t               cmd_r;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  psl_status_t           status_r;
  psl_status_t           status_nxt;
  psl_out_t              out_rsp_r;
  psl_ctrl_t             ctrl;
  logic                  accept;
  logic [CMP_W-1:0]      pos_w;
  logic [CMP_W-1:0]      cnt_w;
  logic [CMP_W-1:0]      tgt;
  logic                  pos_nz;
  logic                  in_rng;
  logic                  ins_rng;
  logic                  full;
  logic [DATA_WIDTH-1:0] ent  [DEPTH];
  logic [DATA_WIDTH-1:0] taps [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;

  assign accept = start && !busy;
  assign busy   = ph1_r;

  // Pipeline phase bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph1_r       <= 1'b0;
      ph2_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ph1_r       <= accept;
      ph2_r       <= ph1_r;
      out_valid_r <= ph2_r;
    end
  end

  // Capture the request.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_req;
    end
  end

  // Range and capacity checks against the current length.
  assign pos_w   = CMP_W'(cmd_r.position);
  assign cnt_w   = CMP_W'(count_r);
  assign tgt     = pos_w - CMP_W'(1);
  assign pos_nz  = (cmd_r.position != 8'd0);
  assign in_rng  = pos_nz && (tgt < cnt_w);
  assign ins_rng = pos_nz && (tgt <= cnt_w);
  assign full    = (cnt_w == CMP_W'(DEPTH));

  // Decode the command into cell enables, the new count and the status.
  always_comb begin
    ctrl        = '0;
    ctrl.tgt    = tgt;
    ctrl.data   = to_data(cmd_r.value);
    count_nxt   = count_r;
    status_nxt  = ST_OK;
    case (cmd_r.operation)
      OP_READ: begin
        if (in_rng) begin
          ctrl.rd_en = ph1_r;
        end else begin
          status_nxt = ST_RANGE;
        end
      end
      OP_WRITE: begin
        if (in_rng) begin
          ctrl.wr_en = ph1_r;
        end else begin
          status_nxt = ST_RANGE;
        end
      end
      OP_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else if (!ins_rng) begin
          status_nxt = ST_RANGE;
        end else begin
          ctrl.ins_en = ph1_r;
          count_nxt   = count_r + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (in_rng) begin
          ctrl.del_en = ph1_r;
          count_nxt   = count_r - CNT_W'(1);
        end else begin
          status_nxt = ST_RANGE;
        end
      end
      default: begin
        status_nxt = ST_RANGE;
      end
    endcase
  end

  // Length and status are committed in the execute cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ph1_r) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ph1_r) begin
      status_r <= status_nxt;
    end
  end

  // The row of list cells, each linked to both neighbors.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_e;
    logic [DATA_WIDTH-1:0] next_e;

    if (i == 0) begin : g_first
      assign prev_e = '0;
    end else begin : g_mid_lo
      assign prev_e = ent[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_mid_hi
      assign next_e = ent[i+1];
    end

    psl_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .cell_idx   (CMP_W'(i)),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .entry      (ent[i]),
      .rd_tap     (taps[i])
    );
  end

  psl_rdtree u_rdtree (
    .clk     (clk),
    .taps    (taps),
    .rd_data (rd_data)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (ph2_r) begin
      out_rsp_r.read_value <= from_data(rd_data);
      out_rsp_r.status     <= status_r;
      out_rsp_r.length     <= to_len(count_r);
      out_rsp_r.empty_res  <= (count_r == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // Every request gives exactly one result, after the ph1_r and ph2_r phases.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##3 out_valid)
    else $error("result strobe missing after request");

  // busy never lasts more than one cycle.
  a_busy_short: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held for two cycles");

  // The length only moves in the execute cycle.
  a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !ph1_r |=> $stable(count_r))
    else $error("length changed outside execute cycle");

  // The length never passes the capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CMP_W'(DEPTH))
    else $error("length above capacity");

  // A failed request never returns data.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.status != ST_OK) |-> (out_rsp.read_value == 32'd0))
    else $error("data returned with error status");

endmodule
